// ----- rtl/core/gtfr_pkg.sv -----
// Shared types, constants and microcode ROM of the glyph text frame renderer.
package gtfr_pkg;

    // Operation codes carried in the mode field
    localparam logic [2:0] MODE_LOAD    = 3'd0;
    localparam logic [2:0] MODE_RESTART = 3'd1;
    localparam logic [2:0] MODE_DRAW    = 3'd2;
    localparam logic [2:0] MODE_CLEAR   = 3'd3;
    localparam logic [2:0] MODE_REFRESH = 3'd4;

    // Status codes
    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_NOFONT = 2'd2;

    // Panel commands
    localparam logic [7:0] CMD_COL_LO = 8'h00;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;

    // Font layout
    localparam int GLYPH_BYTES = 25;
    localparam int GLYPH_COLS  = 12;
    localparam int FIRST_CODE  = 32;

    // Microcode step addresses
    typedef logic [3:0] t_step;
    localparam t_step ST_RCLR = 4'd0;   // clearing pass after reset
    localparam t_step ST_IDLE = 4'd1;
    localparam t_step ST_LOAD = 4'd2;
    localparam t_step ST_RST  = 4'd3;
    localparam t_step ST_DCHK = 4'd4;
    localparam t_step ST_DWID = 4'd5;
    localparam t_step ST_DRD  = 4'd6;
    localparam t_step ST_DADV = 4'd7;
    localparam t_step ST_CLR  = 4'd8;
    localparam t_step ST_RRD  = 4'd9;
    localparam t_step ST_ROUT = 4'd10;
    localparam t_step ST_DONE = 4'd11;

    // Jump conditions: taken -> tgt_t, otherwise -> tgt_f
    typedef enum logic [2:0] {
        JC_ALWAYS,
        JC_ACCEPT,      // taken target comes from the mode dispatch
        JC_SKIP,
        JC_PAIR_MORE,
        JC_CLR_MORE,
        JC_OUT_BUSY
    } t_jcond;

    typedef struct packed {
        logic   rdy;
        logic   font_wr;
        logic   col_zero;
        logic   chk;
        logic   wid_rd;
        logic   pair_rd;
        logic   idx_clr;
        logic   idx_inc;
        logic   clr_wr;
        logic   advance;
        logic   ref_out;
        logic   result;
        t_jcond jc;
        t_step  tgt_t;
        t_step  tgt_f;
    } t_uword;

    // Datapath conditions seen by the sequencer
    typedef struct packed {
        logic accept;
        logic skip;
        logic pair_last;
        logic clr_last;
        logic out_free;
    } t_flags;

    function automatic t_step mode_entry(input logic [2:0] mode);
        t_step s;
        unique case (mode)
            MODE_LOAD:    s = ST_LOAD;
            MODE_RESTART: s = ST_RST;
            MODE_DRAW:    s = ST_DCHK;
            MODE_CLEAR:   s = ST_CLR;
            MODE_REFRESH: s = ST_RRD;
            default:      s = ST_DONE;
        endcase
        return s;
    endfunction

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w       = '0;
        w.jc    = JC_ALWAYS;
        w.tgt_t = ST_IDLE;
        w.tgt_f = ST_IDLE;
        unique case (step)
            ST_RCLR: begin
                w.clr_wr  = 1'b1;
                w.idx_inc = 1'b1;
                w.jc      = JC_CLR_MORE;
                w.tgt_t   = ST_RCLR;
                w.tgt_f   = ST_IDLE;
            end
            ST_IDLE: begin
                w.rdy     = 1'b1;
                w.idx_clr = 1'b1;
                w.jc      = JC_ACCEPT;
                w.tgt_f   = ST_IDLE;
            end
            ST_LOAD: begin
                w.font_wr = 1'b1;
                w.tgt_t   = ST_DONE;
            end
            ST_RST: begin
                w.col_zero = 1'b1;
                w.tgt_t    = ST_DONE;
            end
            ST_DCHK: begin
                w.chk   = 1'b1;
                w.jc    = JC_SKIP;
                w.tgt_t = ST_DONE;
                w.tgt_f = ST_DWID;
            end
            ST_DWID: begin
                w.wid_rd = 1'b1;
                w.tgt_t  = ST_DRD;
            end
            ST_DRD: begin
                w.pair_rd = 1'b1;
                w.idx_inc = 1'b1;
                w.jc      = JC_PAIR_MORE;
                w.tgt_t   = ST_DRD;
                w.tgt_f   = ST_DADV;
            end
            ST_DADV: begin
                w.advance = 1'b1;
                w.tgt_t   = ST_DONE;
            end
            ST_CLR: begin
                w.clr_wr  = 1'b1;
                w.idx_inc = 1'b1;
                w.jc      = JC_CLR_MORE;
                w.tgt_t   = ST_CLR;
                w.tgt_f   = ST_DONE;
            end
            ST_RRD: begin
                w.tgt_t = ST_ROUT;
            end
            ST_ROUT: begin
                w.ref_out = 1'b1;
                w.tgt_t   = ST_DONE;
            end
            ST_DONE: begin
                w.result = 1'b1;
                w.jc     = JC_OUT_BUSY;
                w.tgt_t  = ST_DONE;
                w.tgt_f  = ST_IDLE;
            end
            default: begin
                w.tgt_t = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/core/gtfr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gtfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/gtfr_seq.sv -----
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
module gtfr_seq import gtfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_flags     i_flags,
    input  logic [2:0] i_mode,
    output t_uword     o_cw
);

    t_step  r_step;
    t_step  n_step;
    t_uword cw;
    logic   taken;

    assign cw = ucode(r_step);

    always_comb begin
        unique case (cw.jc)
            JC_ALWAYS:    taken = 1'b1;
            JC_ACCEPT:    taken = i_flags.accept;
            JC_SKIP:      taken = i_flags.skip;
            JC_PAIR_MORE: taken = !i_flags.pair_last;
            JC_CLR_MORE:  taken = !i_flags.clr_last;
            JC_OUT_BUSY:  taken = !i_flags.out_free;
            default:      taken = 1'b0;
        endcase
        if (!taken) begin
            n_step = cw.tgt_f;
        end else if (cw.jc == JC_ACCEPT) begin
            n_step = mode_entry(i_mode);
        end else begin
            n_step = cw.tgt_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_RCLR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_cw = cw;

endmodule

// ----- rtl/core/glyph_text_frame_renderer.sv -----
// Top level: text renderer into a paged frame store with panel refresh streaming.
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+------------------------------------------
//  input    | i_in_valid / o_in_ready    | i_mode i_line_sel i_char_code i_font_addr
//           |                            | i_font_byte
//  output   | o_out_valid / i_out_ready  | o_out_byte o_is_data o_frame_end o_status
//           |                            | o_column
//
// A draw that is not skipped runs the glyph column loop: one font byte pair per
// cycle from two font copies, written in the following cycle to the two frame
// banks. After reset a clearing pass zeroes the frame banks; no transfer is
// accepted until it ends. A stalled output holds one result; the next item is
// taken meanwhile and waits in its final step for the register.
module glyph_text_frame_renderer import gtfr_pkg::*; #(
    parameter int GLYPH_COUNT = 96,
    parameter int COLUMNS     = 128
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_mode,
    input  logic        i_line_sel,
    input  logic [7:0]  i_char_code,
    input  logic [11:0] i_font_addr,
    input  logic [7:0]  i_font_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_is_data,
    output logic        o_frame_end,
    output logic [1:0]  o_status,
    output logic [7:0]  o_column
);

    localparam int FONT_BYTES = GLYPH_BYTES * GLYPH_COUNT;
    localparam int FONT_AW    = $clog2(FONT_BYTES);
    localparam int BANK_DEPTH = 2 * COLUMNS;
    localparam int FB_AW      = $clog2(BANK_DEPTH);
    localparam int PAGE_SEQ   = COLUMNS + 3;
    localparam int RK_W       = $clog2(PAGE_SEQ);

    // Sequencer control
    t_uword cw;
    t_flags flags;
    logic   accept;
    logic   out_free;

    // Latched item
    logic             r_line;
    logic [7:0]       r_code;
    logic [11:0]      r_faddr;
    logic [7:0]       r_fbyte;

    // Text line state
    logic [7:0]       r_upper_col;
    logic [7:0]       r_lower_col;
    logic [7:0]       r_pos;
    logic [7:0]       r_adv;
    logic [FONT_AW-1:0] r_off;
    logic [FB_AW-1:0] r_idx;

    // Draw pipeline: font read data is consumed in the cycle after the read is issued
    logic             r_wid_pend;
    logic             r_pair_pend;
    logic [FB_AW-1:0] r_wr_addr;

    // Refresh position kept as page and step within the page
    logic [1:0]       r_ref_page;
    logic [RK_W-1:0]  r_ref_k;

    // Result under construction
    logic [1:0]       r_status;
    logic [7:0]       r_obyte;
    logic             r_isdata;
    logic             r_fend;

    // Output register
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_isdata;
    logic             r_out_fend;
    logic [1:0]       r_out_status;
    logic [7:0]       r_out_column;

    // Memory ports
    logic               font_we;
    logic [FONT_AW-1:0] font_waddr;
    logic [FONT_AW-1:0] fa_raddr;
    logic [FONT_AW-1:0] fb_raddr;
    logic [7:0]         fa_q;
    logic [7:0]         fb_q;
    logic               bank_we;
    logic [FB_AW-1:0]   bank_waddr;
    logic [7:0]         b0_wdata;
    logic [7:0]         b1_wdata;
    logic [FB_AW-1:0]   bank_raddr;
    logic [7:0]         b0_q;
    logic [7:0]         b1_q;

    // Combinational helpers
    logic [7:0]       pos_sel;
    logic             line_full;
    logic             bad_code;
    logic [7:0]       gidx;
    logic [12:0]      off_full;
    logic [8:0]       adv_sum;
    logic [7:0]       adv_col;
    logic [FONT_AW-1:0] pair_base;
    logic             ref_last_k;
    logic [7:0]       ref_byte;
    logic [12:0]      faddr_ext;

    gtfr_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .i_mode  (i_mode),
        .o_cw    (cw)
    );

    assign o_in_ready = cw.rdy;
    assign accept     = i_in_valid && cw.rdy;
    assign out_free   = !r_out_valid || i_out_ready;

    // Draw checks: line full wins over the font range test
    assign pos_sel   = r_line ? r_lower_col : r_upper_col;
    assign line_full = {1'b0, pos_sel} >= 9'(COLUMNS - GLYPH_COLS);
    assign bad_code  = (r_code < 8'(FIRST_CODE))
                    || ({1'b0, r_code} >= 9'(FIRST_CODE + GLYPH_COUNT));
    assign gidx      = r_code - 8'(FIRST_CODE);
    assign off_full  = 13'(gidx) * 13'(GLYPH_BYTES);

    assign flags.accept    = accept;
    assign flags.skip      = line_full || bad_code;
    assign flags.pair_last = r_idx == FB_AW'(GLYPH_COLS - 1);
    assign flags.clr_last  = r_idx == FB_AW'(BANK_DEPTH - 1);
    assign flags.out_free  = out_free;

    // Advance with saturation at 255
    assign adv_sum = {1'b0, r_pos} + {1'b0, r_adv};
    assign adv_col = adv_sum[8] ? 8'hFF : adv_sum[7:0];

    // Font store, two copies so both bytes of a column pair are read in the same cycle
    assign faddr_ext  = {1'b0, r_faddr};
    assign font_we    = cw.font_wr && (faddr_ext < 13'(FONT_BYTES));
    assign font_waddr = FONT_AW'(r_faddr);
    assign pair_base  = r_off + (FONT_AW'(r_idx) << 1);
    assign fa_raddr   = cw.wid_rd ? r_off : pair_base + FONT_AW'(1);
    assign fb_raddr   = pair_base + FONT_AW'(2);

    gtfr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font_a (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (font_waddr),
        .i_wdata (r_fbyte),
        .i_raddr (fa_raddr),
        .o_rdata (fa_q)
    );

    gtfr_ram #(.WIDTH(8), .DEPTH(FONT_BYTES)) u_font_b (
        .i_clk   (i_clk),
        .i_we    (font_we),
        .i_waddr (font_waddr),
        .i_wdata (r_fbyte),
        .i_raddr (fb_raddr),
        .o_rdata (fb_q)
    );

    // Frame banks: bank 0 holds pages 0 and 2, bank 1 holds pages 1 and 3
    assign bank_we    = r_pair_pend || cw.clr_wr;
    assign bank_waddr = cw.clr_wr ? r_idx : r_wr_addr;
    assign b0_wdata   = cw.clr_wr ? 8'h00 : fa_q;
    assign b1_wdata   = cw.clr_wr ? 8'h00 : fb_q;
    assign bank_raddr = (r_ref_page[1] ? FB_AW'(COLUMNS) : FB_AW'(0))
                      + FB_AW'(r_ref_k - RK_W'(3));

    gtfr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank0 (
        .i_clk   (i_clk),
        .i_we    (bank_we),
        .i_waddr (bank_waddr),
        .i_wdata (b0_wdata),
        .i_raddr (bank_raddr),
        .o_rdata (b0_q)
    );

    gtfr_ram #(.WIDTH(8), .DEPTH(BANK_DEPTH)) u_bank1 (
        .i_clk   (i_clk),
        .i_we    (bank_we),
        .i_waddr (bank_waddr),
        .i_wdata (b1_wdata),
        .i_raddr (bank_raddr),
        .o_rdata (b1_q)
    );

    // Refresh byte: three commands, then the page's data
    assign ref_last_k = r_ref_k == RK_W'(PAGE_SEQ - 1);

    always_comb begin
        case (r_ref_k)
            RK_W'(0): ref_byte = CMD_COL_LO;
            RK_W'(1): ref_byte = CMD_COL_HI;
            RK_W'(2): ref_byte = CMD_PAGE | {6'b0, r_ref_page};
            default:  ref_byte = r_ref_page[0] ? b1_q : b0_q;
        endcase
    end

    // Item and datapath payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_line  <= i_line_sel;
            r_code  <= i_char_code;
            r_faddr <= i_font_addr;
            r_fbyte <= i_font_byte;
        end
        if (cw.chk) begin
            r_pos <= pos_sel;
            r_off <= off_full[FONT_AW-1:0];
        end
        if (r_wid_pend) begin
            r_adv <= fa_q;
        end
        if (cw.pair_rd) begin
            r_wr_addr <= (r_line ? FB_AW'(COLUMNS) : FB_AW'(0))
                       + FB_AW'(r_pos) + r_idx;
        end
        if (accept) begin
            r_status <= STAT_DONE;
            r_obyte  <= 8'h00;
            r_isdata <= 1'b0;
            r_fend   <= 1'b0;
        end else if (cw.chk) begin
            r_status <= line_full ? STAT_FULL : (bad_code ? STAT_NOFONT : STAT_DONE);
        end else if (cw.ref_out) begin
            r_obyte  <= ref_byte;
            r_isdata <= r_ref_k >= RK_W'(3);
            r_fend   <= ref_last_k && (r_ref_page == 2'd3);
        end
        if (cw.result && out_free) begin
            r_out_byte   <= r_obyte;
            r_out_isdata <= r_isdata;
            r_out_fend   <= r_fend;
            r_out_status <= r_status;
            r_out_column <= r_line ? r_lower_col : r_upper_col;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_col <= 8'h00;
            r_lower_col <= 8'h00;
            r_idx       <= '0;
            r_wid_pend  <= 1'b0;
            r_pair_pend <= 1'b0;
            r_ref_page  <= 2'd0;
            r_ref_k     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_wid_pend  <= cw.wid_rd;
            r_pair_pend <= cw.pair_rd;
            if (cw.idx_clr) begin
                r_idx <= '0;
            end else if (cw.idx_inc) begin
                r_idx <= r_idx + FB_AW'(1);
            end
            if (cw.col_zero) begin
                if (r_line) r_lower_col <= 8'h00;
                else        r_upper_col <= 8'h00;
            end else if (cw.advance) begin
                if (r_line) r_lower_col <= adv_col;
                else        r_upper_col <= adv_col;
            end
            if (cw.ref_out) begin
                if (ref_last_k) begin
                    r_ref_k    <= '0;
                    r_ref_page <= r_ref_page + 2'd1;
                end else begin
                    r_ref_k <= r_ref_k + RK_W'(1);
                end
            end
            if (cw.result && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_is_data   = r_out_isdata;
    assign o_frame_end = r_out_fend;
    assign o_status    = r_out_status;
    assign o_column    = r_out_column;

    // Clearing pass holds off input right after reset
    a_reset_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_in_ready)
        else $error("input ready during post-reset clearing pass");

    a_no_wr_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cw.clr_wr && r_pair_pend))
        else $error("frame clear and glyph write in the same cycle");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cw.pair_rd |-> (r_idx < FB_AW'(GLYPH_COLS)))
        else $error("glyph column index out of range");

    a_fend_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_is_data && (o_status == STAT_DONE)))
        else $error("frame end on a non-data result");

    a_skip_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != STAT_DONE)) |-> ((o_out_byte == 8'h00) && !o_is_data))
        else $error("skipped draw carries refresh data");

endmodule
